### rtl/tcc_pkg.sv
// ============================================================================
// Text cursor controller package
// Shared widths, codes and transfer types of the text cursor controller.
// ============================================================================
package tcc_pkg;

    // Screen geometry limits.
    localparam int MAX_COLS = 160;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 6;

    // Configuration port.
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TAB_SHIFT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_ENABLE = 3'd5;

    // Character codes.
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // A character yields at most three commands.
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap naturally
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_MOVE        = 2'd0,
        KIND_DRAW        = 2'd1,
        KIND_SCROLL_UP   = 2'd2,
        KIND_SCROLL_DOWN = 2'd3
    } tcc_kind_t;

    typedef struct packed {
        logic [COL_W-1:0] window_left;
        logic [COL_W-1:0] window_right;
        logic [ROW_W-1:0] window_top;
        logic [ROW_W-1:0] window_bottom;
        logic [2:0]       tab_shift;
        logic             scroll_enable;
    } tcc_cfg_t;

    typedef struct packed {
        tcc_kind_t        kind;
        logic [7:0]       glyph;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] line;
    } tcc_result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]              count;
        tcc_result_t [MAX_RESULTS-1:0]     res;
    } tcc_packet_t;

endpackage

### rtl/tcc_cfg.sv
// ============================================================================
// Text cursor controller configuration registers
// Holds the window, tab and scroll settings; columns saturate, rows are masked.
// ============================================================================
module tcc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tcc_pkg::tcc_cfg_t               cfg
);
    import tcc_pkg::*;

    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS - 1);

    tcc_cfg_t         cfg_reg;
    tcc_cfg_t         cfg_next;
    logic [COL_W-1:0] col_val;
    logic [ROW_W-1:0] row_val;

    always_comb begin
        col_val  = cfg_data[COL_W-1:0];
        row_val  = cfg_data[ROW_W-1:0];
        if (col_val > COL_LIMIT) begin
            col_val = COL_LIMIT;
        end
        if (row_val > ROW_LIMIT) begin
            row_val = ROW_LIMIT;
        end
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW_LEFT:   cfg_next.window_left   = col_val;
                REG_WINDOW_RIGHT:  cfg_next.window_right  = col_val;
                REG_WINDOW_TOP:    cfg_next.window_top    = row_val;
                REG_WINDOW_BOTTOM: cfg_next.window_bottom = row_val;
                REG_TAB_SHIFT:     cfg_next.tab_shift     = cfg_data[2:0];
                REG_SCROLL_ENABLE: cfg_next.scroll_enable = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_left   <= COL_W'(0);
            cfg_reg.window_right  <= COL_W'(79);
            cfg_reg.window_top    <= ROW_W'(0);
            cfg_reg.window_bottom <= ROW_W'(29);
            cfg_reg.tab_shift     <= 3'd3;
            cfg_reg.scroll_enable <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/tcc_front.sv
// ============================================================================
// Text cursor controller front end
// Classifies each character, updates the cursor and builds its command packet.
// ============================================================================
module tcc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  tcc_pkg::tcc_cfg_t     cfg,
    input  logic                  queue_full,
    output logic                  push,
    output tcc_pkg::tcc_packet_t  packet
);
    import tcc_pkg::*;

    function automatic tcc_result_t mk(input tcc_kind_t kind, input logic [7:0] glyph,
                                       input logic [COL_W-1:0] column,
                                       input logic [ROW_W-1:0] line);
        tcc_result_t r;
        r.kind   = kind;
        r.glyph  = glyph;
        r.column = column;
        r.line   = line;
        return r;
    endfunction

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             dn_step, dn_scroll, up_step, up_scroll;
    logic [ROW_W-1:0] dn_row, up_row;
    logic [COL_W-1:0] right_m1;
    logic [8:0]       tab_base;
    logic [15:0]      tab_full;
    logic [COL_W-1:0] tab_col;
    tcc_result_t      scroll_up_res, scroll_dn_res;

    always_comb begin
        dn_step   = row_reg < cfg.window_bottom;
        dn_row    = dn_step ? row_reg + ROW_W'(1) : row_reg;
        dn_scroll = !dn_step && cfg.scroll_enable;
        up_step   = cfg.window_top < row_reg;
        up_row    = up_step ? row_reg - ROW_W'(1) : row_reg;
        up_scroll = !up_step && cfg.scroll_enable;
        right_m1  = (cfg.window_right == '0) ? '0 : cfg.window_right - COL_W'(1);

        // Next tab stop; the stop may lie far beyond the screen for wide shifts.
        tab_base = {1'b0, col_reg >> cfg.tab_shift} + 9'd1;
        tab_full = {7'b0, tab_base} << cfg.tab_shift;
        tab_col  = (tab_full >= {8'b0, cfg.window_right}) ? right_m1 : tab_full[COL_W-1:0];

        scroll_up_res = mk(KIND_SCROLL_UP, 8'd0, '0, '0);
        scroll_dn_res = mk(KIND_SCROLL_DOWN, 8'd0, '0, '0);
    end

    always_comb begin
        packet   = '0;
        col_next = col_reg;
        row_next = row_reg;
        case (s_tdata)
            CHAR_BS: begin
                if (cfg.window_left < col_reg) begin
                    col_next         = col_reg - COL_W'(1);
                    packet.count     = 2'd2;
                    packet.res[0]    = mk(KIND_MOVE, 8'd0, col_next, row_reg);
                    packet.res[1]    = mk(KIND_DRAW, CHAR_SPACE, col_next, row_reg);
                end else begin
                    col_next = right_m1;
                    row_next = up_row;
                    if (up_scroll) begin
                        packet.count  = 2'd3;
                        packet.res[0] = scroll_dn_res;
                        packet.res[1] = mk(KIND_MOVE, 8'd0, right_m1, up_row);
                        packet.res[2] = mk(KIND_DRAW, CHAR_SPACE, right_m1, up_row);
                    end else begin
                        packet.count  = 2'd2;
                        packet.res[0] = mk(KIND_MOVE, 8'd0, right_m1, up_row);
                        packet.res[1] = mk(KIND_DRAW, CHAR_SPACE, right_m1, up_row);
                    end
                end
            end
            CHAR_CR: begin
                col_next      = cfg.window_left;
                packet.count  = 2'd1;
                packet.res[0] = mk(KIND_MOVE, 8'd0, cfg.window_left, row_reg);
            end
            CHAR_TAB: begin
                col_next      = tab_col;
                packet.count  = 2'd1;
                packet.res[0] = mk(KIND_MOVE, 8'd0, tab_col, row_reg);
            end
            CHAR_VT: begin
                row_next = dn_row;
                if (dn_scroll) begin
                    packet.count  = 2'd2;
                    packet.res[0] = scroll_up_res;
                    packet.res[1] = mk(KIND_MOVE, 8'd0, col_reg, dn_row);
                end else begin
                    packet.count  = 2'd1;
                    packet.res[0] = mk(KIND_MOVE, 8'd0, col_reg, dn_row);
                end
            end
            default: begin
                // Newline and every code not decoded above share the step-down tail.
                if (s_tdata == CHAR_LF) begin
                    packet.res[0] = mk(KIND_MOVE, 8'd0, cfg.window_left, row_reg);
                end else begin
                    packet.res[0] = mk(KIND_DRAW, s_tdata, col_reg, row_reg);
                end
                if (s_tdata != CHAR_LF && col_reg < cfg.window_right) begin
                    col_next      = col_reg + COL_W'(1);
                    packet.count  = 2'd2;
                    packet.res[1] = mk(KIND_MOVE, 8'd0, col_next, row_reg);
                end else begin
                    col_next = cfg.window_left;
                    row_next = dn_row;
                    if (dn_scroll) begin
                        packet.count  = 2'd3;
                        packet.res[1] = scroll_up_res;
                        packet.res[2] = mk(KIND_MOVE, 8'd0, cfg.window_left, dn_row);
                    end else begin
                        packet.count  = 2'd2;
                        packet.res[1] = mk(KIND_MOVE, 8'd0, cfg.window_left, dn_row);
                    end
                end
            end
        endcase
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef SYNTHESIS
    a_packet_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (packet.count != 2'd0))
        else $error("front pushed an empty command packet");
`endif

endmodule

### rtl/tcc_queue.sv
// ============================================================================
// Text cursor controller command queue
// Short first-in first-out buffer of command packets between front and back.
// ============================================================================
module tcc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tcc_pkg::tcc_packet_t  push_packet,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output tcc_pkg::tcc_packet_t  head_packet
);
    import tcc_pkg::*;

    tcc_packet_t         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full        = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid  = (count_reg != '0);
    assign head_packet = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_packet;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("command queue read while empty");
`endif

endmodule

### rtl/tcc_back.sv
// ============================================================================
// Text cursor controller back end
// Issues each packet's commands via an output register, one per ready cycle.
// ============================================================================
module tcc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  tcc_pkg::tcc_packet_t  head_packet,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);
    import tcc_pkg::*;

    logic [RES_CNT_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    tcc_result_t          res_reg, res_next;
    logic                 last_reg, last_next;
    logic                 out_free;
    logic                 idx_last;

    assign out_free = !valid_reg || m_tready;
    assign idx_last = (idx_reg == head_packet.count - RES_CNT_W'(1));
    assign pop      = out_free && head_valid && idx_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        if (out_free) begin
            valid_next = head_valid;
            if (head_valid) begin
                res_next  = head_packet.res[idx_reg];
                last_next = idx_last;
                idx_next  = idx_last ? '0 : idx_reg + RES_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.line, res_reg.column, res_reg.glyph};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_idx_in_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (idx_reg < head_packet.count))
        else $error("result index runs past the packet");
    a_scroll_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (res_reg.kind == KIND_SCROLL_UP || res_reg.kind == KIND_SCROLL_DOWN))
        |-> !last_reg)
        else $error("scroll command closed a character");
`endif

endmodule

### rtl/text_cursor_controller_core.sv
// ============================================================================
// Text cursor controller core
// Tracks a text cursor inside a window and streams draw, move, scroll commands.
// ============================================================================
// A character transfer is written into the queue; its first command is then
// loaded into the output register and transfers out from there.
// Throughput: one command per cycle while the receiver is ready; a character
// is accepted whenever the queue has room and yields one to three commands.
// Reset: synchronous, active low; cursor to column 0, row 0, registers to
// their defaults, queue and output emptied.
module text_cursor_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream: tdata[7:0] = char_code.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    // Command stream: tdata[7:0] = glyph, [15:8] = column, [21:16] = line,
    // [23:22] zero.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,
    // tuser[1:0] = kind (move, draw, scroll up, scroll down).
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [tcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcc_pkg::*;

    tcc_cfg_t    cfg;
    logic        queue_full;
    logic        push;
    tcc_packet_t push_packet;
    logic        pop;
    logic        head_valid;
    tcc_packet_t head_packet;

    // Configuration registers; column bounds saturate, row bounds are masked.
    tcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The front end owns the cursor. It decodes each character in the cycle
    // of its transfer and builds the whole command list for it, so the next
    // character can follow immediately as long as the queue has room.
    tcc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .packet     (push_packet)
    );

    // The queue decouples the two halves so a stalled output does not stall
    // decoding until the queue fills.
    tcc_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_packet (push_packet),
        .full        (queue_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_packet (head_packet)
    );

    // The back end walks through the head packet one command per transfer and
    // marks the final command of each character with tlast.
    tcc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_packet (head_packet),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

### bench/text_cursor_controller_core_tb.sv
// ============================================================================
// Text cursor controller core testbench
// Streams character codes into the core under several window settings and
// checks every draw, move and scroll command against a cycle-free predictor
// of the cursor, with random idling on the character and command streams.
// ============================================================================
`timescale 1ns / 100ps

module text_cursor_controller_core_tb;

    import tcc_pkg::*;

    // Register indexes that the core does not decode; writes to them must
    // leave every setting alone.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    // With nothing stalling, the last command of a character passes through
    // the queue and the output register before it transfers out, so a handful
    // of quiet cycles is enough to call the core idle.
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 40;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 42;
    localparam int DIR_N         = 18;

    // One command as the core should emit it.
    typedef struct packed {
        tcc_kind_t        kind;
        logic [7:0]       glyph;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
    } cmd_t;

    // One directed character. Where pinned is set, the first command of the
    // character is also compared with the values typed into the row.
    typedef struct packed {
        logic [7:0]       code;
        logic             pinned;
        tcc_kind_t        kind;
        logic [7:0]       glyph;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } stim_row_t;

    // Directed characters, run with the reset settings (window 0..79 by
    // 0..29, tab stops every 8 columns, scrolling on) from the home position.
    localparam stim_row_t DIRECTED_ROWS [DIR_N] = '{
        // Plain characters, lowest and highest codes, at the top left corner.
        '{8'h41,    1'b1, KIND_DRAW,        8'h41, 8'd0,  6'd0},
        '{8'hFF,    1'b1, KIND_DRAW,        8'hFF, 8'd1,  6'd0},
        '{8'h00,    1'b1, KIND_DRAW,        8'h00, 8'd2,  6'd0},
        // Carriage return back to the left column.
        '{CHAR_CR,  1'b1, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        // Backspace at the top left wraps to the right edge minus one and
        // scrolls the window down first.
        '{CHAR_BS,  1'b1, KIND_SCROLL_DOWN, 8'h00, 8'd0,  6'd0},
        // Tab past the right edge is clamped to the right edge minus one.
        '{CHAR_TAB, 1'b1, KIND_MOVE,        8'h00, 8'd78, 6'd0},
        // Draw up to the right edge, then wrap to the next row.
        '{8'h42,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{8'h43,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{CHAR_VT,  1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{CHAR_LF,  1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{CHAR_TAB, 1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{CHAR_BS,  1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        // Codes next to the control codes and other boundaries are drawn.
        '{8'h7F,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{8'h80,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{8'h20,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{8'h0C,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{8'h0E,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0},
        '{8'h07,    1'b0, KIND_MOVE,        8'h00, 8'd0,  6'd0}
    };

    // Idling per phase, cycled: none, sender only, receiver only, both.
    localparam int SEND_IDLE [4] = '{0, 46, 0, 29};
    localparam int RECV_STALL [4] = '{0, 0, 46, 29};

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    text_cursor_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Commands still owed by the core, oldest first, and the typed first
    // commands of the directed characters.
    cmd_t      cmd_q [$];
    stim_row_t pin_q [$];

    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned quiet_cycles;

    // Predictor copy of the settings and of the cursor.
    logic [COL_W-1:0] win_left;
    logic [COL_W-1:0] win_right;
    logic [ROW_W-1:0] win_top;
    logic [ROW_W-1:0] win_bottom;
    logic [2:0]       tab_sh;
    logic             scroll_on;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Cursor predictor
    // ------------------------------------------------------------------

    function automatic void emit_cmd(tcc_kind_t kind, logic [7:0] glyph,
                                     logic [COL_W-1:0] column, logic [ROW_W-1:0] row);
        cmd_t c;
        c.kind   = kind;
        c.glyph  = glyph;
        c.column = column;
        c.row    = row;
        c.last   = 1'b0;
        cmd_q.push_back(c);
    endfunction

    // Column that a left wrap and an oversized tab land on.
    function automatic logic [COL_W-1:0] edge_col();
        return (win_right == '0) ? '0 : win_right - 1'b1;
    endfunction

    // Next row; at the bottom the row stays and the text scrolls up if enabled.
    function automatic void advance_line();
        if (cur_row < win_bottom) begin
            cur_row = cur_row + 1'b1;
        end else if (scroll_on) begin
            emit_cmd(KIND_SCROLL_UP, 8'h00, '0, '0);
        end
        emit_cmd(KIND_MOVE, 8'h00, cur_col, cur_row);
    endfunction

    function automatic void predict_commands(logic [7:0] code);
        int stop;
        case (code)
            CHAR_BS: begin
                if (win_left < cur_col) begin
                    cur_col = cur_col - 1'b1;
                    emit_cmd(KIND_MOVE, 8'h00, cur_col, cur_row);
                end else begin
                    // Left wrap goes to the previous row, scrolling down at
                    // the top if scrolling is on.
                    cur_col = edge_col();
                    if (win_top < cur_row) begin
                        cur_row = cur_row - 1'b1;
                    end else if (scroll_on) begin
                        emit_cmd(KIND_SCROLL_DOWN, 8'h00, '0, '0);
                    end
                    emit_cmd(KIND_MOVE, 8'h00, cur_col, cur_row);
                end
                emit_cmd(KIND_DRAW, CHAR_SPACE, cur_col, cur_row);
            end
            CHAR_CR: begin
                cur_col = win_left;
                emit_cmd(KIND_MOVE, 8'h00, cur_col, cur_row);
            end
            CHAR_LF: begin
                cur_col = win_left;
                emit_cmd(KIND_MOVE, 8'h00, cur_col, cur_row);
                advance_line();
            end
            CHAR_VT: begin
                advance_line();
            end
            CHAR_TAB: begin
                // Worked out wide: a shift of seven can reach 256.
                stop = ((int'(cur_col) >> tab_sh) + 1) << tab_sh;
                if (stop >= int'(win_right)) begin
                    stop = int'(edge_col());
                end
                cur_col = stop[COL_W-1:0];
                emit_cmd(KIND_MOVE, 8'h00, cur_col, cur_row);
            end
            default: begin
                emit_cmd(KIND_DRAW, code, cur_col, cur_row);
                if (cur_col < win_right) begin
                    cur_col = cur_col + 1'b1;
                    emit_cmd(KIND_MOVE, 8'h00, cur_col, cur_row);
                end else begin
                    cur_col = win_left;
                    advance_line();
                end
            end
        endcase
        cmd_q[cmd_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: follows register writes, predicts on every character
    // transfer and checks every command transfer. Everything is sampled at
    // the rising edge, before the nonblocking updates of that edge land.
    // ------------------------------------------------------------------

    logic char_start;

    always @(posedge aclk) begin : monitor
        cmd_t      want;
        cmd_t      got;
        stim_row_t pin;
        if (!aresetn) begin
            win_left   = 8'd0;
            win_right  = 8'd79;
            win_top    = 6'd0;
            win_bottom = 6'd29;
            tab_sh     = 3'd3;
            scroll_on  = 1'b1;
            cur_col    = '0;
            cur_row    = '0;
            cmd_q.delete();
            char_start = 1'b1;
        end else begin
            // Column registers saturate at the screen size; rows keep six bits.
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WINDOW_LEFT:   win_left   = (cfg_data > MAX_COLS - 1) ?
                                                    COL_W'(MAX_COLS - 1) : cfg_data;
                    REG_WINDOW_RIGHT:  win_right  = (cfg_data > MAX_COLS - 1) ?
                                                    COL_W'(MAX_COLS - 1) : cfg_data;
                    REG_WINDOW_TOP:    win_top    = cfg_data[ROW_W-1:0];
                    REG_WINDOW_BOTTOM: win_bottom = cfg_data[ROW_W-1:0];
                    REG_TAB_SHIFT:     tab_sh     = cfg_data[2:0];
                    REG_SCROLL_ENABLE: scroll_on  = cfg_data[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                predict_commands(s_tdata);
            end

            if (m_tvalid && m_tready) begin
                got.kind   = tcc_kind_t'(m_tuser);
                got.glyph  = m_tdata[7:0];
                got.column = m_tdata[15:8];
                got.row    = m_tdata[21:16];
                got.last   = m_tlast;
                if (cmd_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected command: kind=%0d glyph=%02h col=%0d row=%0d last=%0d",
                                 $time, got.kind, got.glyph, got.column, got.row, got.last);
                    end
                end else begin
                    want = cmd_q.pop_front();
                    if (got != want || m_tdata[23:22] != 2'b00) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display({"%0t: command mismatch: expected kind=%0d glyph=%02h ",
                                      "col=%0d row=%0d last=%0d pad=0, got kind=%0d glyph=%02h ",
                                      "col=%0d row=%0d last=%0d pad=%0d"},
                                     $time, want.kind, want.glyph, want.column, want.row,
                                     want.last, got.kind, got.glyph, got.column, got.row,
                                     got.last, m_tdata[23:22]);
                        end
                    end
                end

                // The first command of a directed character is held against
                // the values typed into its row as well.
                if (char_start && pin_q.size() != 0) begin
                    pin = pin_q.pop_front();
                    if (pin.pinned && (got.kind != pin.kind || got.glyph != pin.glyph ||
                                       got.column != pin.column || got.row != pin.row)) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display({"%0t: first command of %02h: expected kind=%0d ",
                                      "glyph=%02h col=%0d row=%0d, got kind=%0d glyph=%02h ",
                                      "col=%0d row=%0d"},
                                     $time, pin.code, pin.kind, pin.glyph, pin.column,
                                     pin.row, got.kind, got.glyph, got.column, got.row);
                        end
                    end
                end
                char_start = m_tlast;
            end
        end
    end

    // Receiver: stalls at random at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a run of cycles with no transfer of any kind ends the run.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("text_cursor_controller_core_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one character and returns at the edge of its transfer. The
    // valid stays high into the next call, so back-to-back characters never
    // see it dropped and raised in the same step.
    task automatic send_char(input logic [7:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Ends the character stream and waits until every owed command is out
    // and the core has had time to settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (cmd_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // Writes every register, plus junk to the two undecoded indexes.
    task automatic load_window(input logic [7:0] left, input logic [7:0] right,
                               input logic [7:0] top, input logic [7:0] bottom,
                               input logic [7:0] shift, input logic [7:0] scroll);
        write_reg(REG_SPARE_A, 8'($urandom));
        write_reg(REG_WINDOW_LEFT, left);
        write_reg(REG_WINDOW_RIGHT, right);
        write_reg(REG_WINDOW_TOP, top);
        write_reg(REG_WINDOW_BOTTOM, bottom);
        write_reg(REG_TAB_SHIFT, shift);
        write_reg(REG_SCROLL_ENABLE, scroll);
        write_reg(REG_SPARE_B, 8'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [7:0] code;
        logic [7:0] base_col;
        logic [7:0] base_row;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed characters with the reset settings.
        for (int r = 0; r < DIR_N; r++) begin
            pin_q.push_back(DIRECTED_ROWS[r]);
            send_char(DIRECTED_ROWS[r].code);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                case (p)
                    // Small window with scrolling and two-column tab stops.
                    1: load_window(8'd2, 8'd9, 8'd3, 8'd6, 8'd1, 8'd1);
                    // Inverted window, tab shift above five, no scrolling.
                    2: load_window(8'd100, 8'd20, 8'd40, 8'd10, 8'd6, 8'd0);
                    // Values past the screen size saturate or are masked.
                    3: load_window(8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'd7, 8'd1);
                    // Everything zero: right edge at zero, single cell.
                    4: load_window(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                    // Full screen.
                    5: load_window(8'd0, 8'd159, 8'd0, 8'd63, 8'd5, 8'd1);
                    // Two-by-two window.
                    7: load_window(8'd5, 8'd6, 8'd2, 8'd3, 8'd2, 8'd1);
                    // Random small window.
                    8: begin
                        base_col = 8'($urandom_range(150));
                        base_row = 8'($urandom_range(60));
                        load_window(base_col, base_col + 8'($urandom_range(9)),
                                    base_row, base_row + 8'($urandom_range(3)),
                                    8'($urandom), 8'($urandom));
                    end
                    // Any byte at all in every register.
                    default: load_window(8'($urandom), 8'($urandom), 8'($urandom),
                                         8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end

            send_idle_pct = SEND_IDLE[p % 4];
            stall_pct     = RECV_STALL[p % 4];

            // Control codes take a large share so that the cursor wanders
            // across the window edges; the rest is any byte.
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 45) begin
                    case ($urandom_range(4))
                        0: code = CHAR_BS;
                        1: code = CHAR_TAB;
                        2: code = CHAR_LF;
                        3: code = CHAR_VT;
                        default: code = CHAR_CR;
                    endcase
                end else begin
                    code = 8'($urandom_range(255));
                end
                send_char(code);
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("text_cursor_controller_core_tb: PASS");
        end else begin
            $display("text_cursor_controller_core_tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tcc_pkg.sv
rtl/tcc_cfg.sv
rtl/tcc_front.sv
rtl/tcc_queue.sv
rtl/tcc_back.sv
rtl/text_cursor_controller_core.sv
bench/text_cursor_controller_core_tb.sv
